// File: rtl/uas3d_pkg.sv
// Package of shared types, constants and operand tables for the upwind advection stencil.
package uas3d_pkg;

    localparam int MAX_SIZE_X_DEF = 64;
    localparam int MAX_SIZE_Y_DEF = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0]  SIZE_X_RESET = 7'd64;
    localparam logic [6:0]  SIZE_Y_RESET = 7'd64;
    localparam logic [15:0] SIZE_Z_RESET = 16'd64;
    localparam logic [15:0] GAIN_RESET   = 16'd655;

    typedef enum logic [1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2,
        CFG_GAIN   = 2'd3
    } cfg_idx_t;

    // Operand words handed from the front to the back through the queue.
    localparam int W_C    = 0;
    localparam int W_XM   = 1;
    localparam int W_XP   = 2;
    localparam int W_YM   = 3;
    localparam int W_YP   = 4;
    localparam int W_ZM   = 5;
    localparam int W_CUR  = 6;
    localparam int W_VX0  = 7;
    localparam int W_VX1  = 8;
    localparam int W_VY0  = 9;
    localparam int W_VY1  = 10;
    localparam int W_VZ0  = 11;
    localparam int W_VZ1  = 12;
    localparam int WORDS  = 13;

    localparam int FLUXES = 6;

    // Even fluxes enter the cell through a low face, odd ones leave through a high face.
    localparam int FLUX_VEL [FLUXES] = '{W_VX0, W_VX1, W_VY0, W_VY1, W_VZ0, W_VZ1};
    localparam int FLUX_UP  [FLUXES] = '{W_XM,  W_C,   W_YM,  W_C,   W_ZM,  W_C};
    localparam int FLUX_DN  [FLUXES] = '{W_C,   W_XP,  W_C,   W_YP,  W_C,   W_CUR};

    typedef struct packed {
        logic [5:0]  pos_x;
        logic [5:0]  pos_y;
        logic [15:0] pos_z;
        logic        last_cell;
    } pos_t;

endpackage

// File: rtl/uas3d_front.sv
// Front end: raster counters, interior classification and the plane delay memories.
module uas3d_front #(
    parameter int MAX_SIZE_X = uas3d_pkg::MAX_SIZE_X_DEF,
    parameter int MAX_SIZE_Y = uas3d_pkg::MAX_SIZE_Y_DEF,
    parameter int DATA_WIDTH = uas3d_pkg::DATA_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic [DATA_WIDTH-1:0]                        cell_value,
    input  logic [DATA_WIDTH-1:0]                        face_vel_x,
    input  logic [DATA_WIDTH-1:0]                        face_vel_y,
    input  logic [DATA_WIDTH-1:0]                        face_vel_z,
    input  logic [6:0]                                   size_x,
    input  logic [6:0]                                   size_y,
    input  logic [15:0]                                  size_z,
    input  logic [uas3d_pkg::QCW-1:0]                    q_count,
    output logic                                         push,
    output logic [uas3d_pkg::WORDS-1:0][DATA_WIDTH-1:0]  push_words,
    output uas3d_pkg::pos_t                              push_pos
);
    import uas3d_pkg::*;

    localparam int XW     = $clog2(MAX_SIZE_X);
    localparam int YW     = $clog2(MAX_SIZE_Y);
    localparam int XW1    = $clog2(MAX_SIZE_X + 1);
    localparam int YW1    = $clog2(MAX_SIZE_Y + 1);
    localparam int AW     = $clog2(MAX_SIZE_X * MAX_SIZE_Y);
    localparam int DEPTH  = 2 ** AW;
    localparam int VDEPTH = 2 ** (AW + 1);

    logic [XW-1:0]  col_reg,  col_next;
    logic [YW-1:0]  row_reg,  row_next;
    logic [15:0]    plane_reg, plane_next;
    logic [AW-1:0]  base_reg, base_next;

    logic [XW1-1:0] sx;
    logic [YW1-1:0] sy;
    logic [15:0]    sz;
    logic           accept;
    logic           interior;
    logic           last;
    logic [AW-1:0]  at, at_p1, at_m1, at_pr, at_mr;
    logic           s0, s1;

    logic [DATA_WIDTH-1:0] val_a [VDEPTH];
    logic [DATA_WIDTH-1:0] val_b [VDEPTH];
    logic [DATA_WIDTH-1:0] val_c [VDEPTH];
    logic [DATA_WIDTH-1:0] vx_mem [DEPTH];
    logic [DATA_WIDTH-1:0] vy_mem [DEPTH];
    logic [DATA_WIDTH-1:0] vz_mem [DEPTH];

    logic [DATA_WIDTH-1:0] rd_c_reg, rd_zm_reg, rd_xm_reg, rd_xp_reg, rd_ym_reg, rd_yp_reg;
    logic [DATA_WIDTH-1:0] rd_vx0_reg, rd_vx1_reg, rd_vy0_reg, rd_vy1_reg, rd_vz0_reg;
    logic [DATA_WIDTH-1:0] s1_cur_reg, s1_vz_reg;
    pos_t                  s1_pos_reg;
    logic                  s1_valid_reg;

    always_comb
    begin
        if (size_x < 7'd3)
            sx = XW1'(3);
        else if (int'(size_x) > MAX_SIZE_X)
            sx = XW1'(MAX_SIZE_X);
        else
            sx = XW1'(size_x);
        if (size_y < 7'd3)
            sy = YW1'(3);
        else if (int'(size_y) > MAX_SIZE_Y)
            sy = YW1'(MAX_SIZE_Y);
        else
            sy = YW1'(size_y);
        sz = (size_z < 16'd3) ? 16'd3 : size_z;
    end

    // A queue slot is held back for the word still in the read stage.
    assign in_stall = ((QCW + 1)'(q_count) + (QCW + 1)'(s1_valid_reg)) >= (QCW + 1)'(QUEUE_DEPTH);
    assign accept   = in_valid && !in_stall;

    assign at    = base_reg + AW'(col_reg);
    assign at_p1 = at + AW'(1);
    assign at_m1 = at - AW'(1);
    assign at_pr = at + AW'(MAX_SIZE_X);
    assign at_mr = at - AW'(MAX_SIZE_X);
    assign s0    = plane_reg[0];
    assign s1    = ~plane_reg[0];

    assign interior = (plane_reg >= 16'd2) && (plane_reg <= sz - 16'd1) &&
                      (col_reg != '0) && (XW1'(col_reg) <= sx - XW1'(2)) &&
                      (row_reg != '0) && (YW1'(row_reg) <= sy - YW1'(2));
    assign last     = (XW1'(col_reg) == sx - XW1'(2)) && (YW1'(row_reg) == sy - YW1'(2)) &&
                      (plane_reg == sz - 16'd1);

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        base_next  = base_reg;
        if (accept)
        begin
            if (XW1'(col_reg) + XW1'(1) >= sx)
            begin
                col_next = '0;
                if (YW1'(row_reg) + YW1'(1) >= sy)
                begin
                    row_next   = '0;
                    base_next  = '0;
                    plane_next = ({1'b0, plane_reg} + 17'd1 >= {1'b0, sz}) ? 16'd0
                                                                         : plane_reg + 16'd1;
                end
                else
                begin
                    row_next  = row_reg + YW'(1);
                    base_next = base_reg + AW'(MAX_SIZE_X);
                end
            end
            else
            begin
                col_next = col_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            plane_reg    <= '0;
            base_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            plane_reg    <= plane_next;
            base_reg     <= base_next;
            s1_valid_reg <= accept && interior;
        end
    end

    // Three copies of the two-plane value window give six read ports.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_a[{s0, at}] <= cell_value;
            val_b[{s0, at}] <= cell_value;
            val_c[{s0, at}] <= cell_value;
            rd_c_reg  <= val_a[{s1, at}];
            rd_zm_reg <= val_a[{s0, at}];
            rd_xm_reg <= val_b[{s1, at_m1}];
            rd_xp_reg <= val_b[{s1, at_p1}];
            rd_ym_reg <= val_c[{s1, at_mr}];
            rd_yp_reg <= val_c[{s1, at_pr}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vx_mem[at] <= face_vel_x;
            vy_mem[at] <= face_vel_y;
            vz_mem[at] <= face_vel_z;
            rd_vx0_reg <= vx_mem[at];
            rd_vx1_reg <= vx_mem[at_p1];
            rd_vy0_reg <= vy_mem[at];
            rd_vy1_reg <= vy_mem[at_pr];
            rd_vz0_reg <= vz_mem[at];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg           <= cell_value;
            s1_vz_reg            <= face_vel_z;
            s1_pos_reg.pos_x     <= 6'(col_reg);
            s1_pos_reg.pos_y     <= 6'(row_reg);
            s1_pos_reg.pos_z     <= plane_reg - 16'd1;
            s1_pos_reg.last_cell <= last;
        end
    end

    always_comb
    begin
        push_words        = '0;
        push_words[W_C]   = rd_c_reg;
        push_words[W_XM]  = rd_xm_reg;
        push_words[W_XP]  = rd_xp_reg;
        push_words[W_YM]  = rd_ym_reg;
        push_words[W_YP]  = rd_yp_reg;
        push_words[W_ZM]  = rd_zm_reg;
        push_words[W_CUR] = s1_cur_reg;
        push_words[W_VX0] = rd_vx0_reg;
        push_words[W_VX1] = rd_vx1_reg;
        push_words[W_VY0] = rd_vy0_reg;
        push_words[W_VY1] = rd_vy1_reg;
        push_words[W_VZ0] = rd_vz0_reg;
        push_words[W_VZ1] = s1_vz_reg;
    end

    assign push     = s1_valid_reg;
    assign push_pos = s1_pos_reg;

endmodule

// File: rtl/uas3d_queue.sv
// Short queue of operand words between the front end and the arithmetic back end.
module uas3d_queue #(
    parameter int WIDTH = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic                      pop,
    output logic [WIDTH-1:0]          rd_data,
    output logic                      empty,
    output logic [uas3d_pkg::QCW-1:0] count
);
    import uas3d_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        count_next = count_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data = slot_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule

// File: rtl/uas3d_back.sv
// Back end: upwind fluxes, flux balance, gain scaling and saturating update.
module uas3d_back #(
    parameter int DATA_WIDTH = uas3d_pkg::DATA_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         q_empty,
    input  logic [uas3d_pkg::WORDS-1:0][DATA_WIDTH-1:0]  q_words,
    input  uas3d_pkg::pos_t                              q_pos,
    output logic                                         pop,
    input  logic [15:0]                                  update_gain,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic [DATA_WIDTH-1:0]                        new_value,
    output logic [5:0]                                   pos_x,
    output logic [5:0]                                   pos_y,
    output logic [15:0]                                  pos_z,
    output logic                                         last_cell
);
    import uas3d_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int BW = PW - FRAC_BITS + 3;
    localparam int GW = BW + 17;
    localparam int DW = GW - FRAC_BITS;
    localparam int RW = DW + 1;

    logic en;

    logic signed [PW-1:0]  prod_next [FLUXES];
    logic signed [PW-1:0]  b1_prod_reg [FLUXES];
    logic [DATA_WIDTH-1:0] b1_c_reg;
    pos_t                  b1_pos_reg;
    logic                  b1_valid_reg;

    logic signed [BW-1:0]  bal_next;
    logic signed [BW-1:0]  b2_bal_reg;
    logic [DATA_WIDTH-1:0] b2_c_reg;
    pos_t                  b2_pos_reg;
    logic                  b2_valid_reg;

    logic signed [GW-1:0]  gain_prod;
    logic signed [DW-1:0]  b3_delta_reg;
    logic [DATA_WIDTH-1:0] b3_c_reg;
    pos_t                  b3_pos_reg;
    logic                  b3_valid_reg;

    logic signed [RW-1:0]  sum;
    logic [DATA_WIDTH-1:0] sat_next;

    logic [DATA_WIDTH-1:0] new_value_reg;
    pos_t                  out_pos_reg;
    logic                  out_valid_reg;

    // The whole back end moves only while the output register can take a word.
    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && !q_empty;

    // A negative face velocity carries the downstream cell, otherwise the upstream one.
    always_comb
    begin
        logic [DATA_WIDTH-1:0] u;
        logic [DATA_WIDTH-1:0] op;
        for (int i = 0; i < FLUXES; i++)
        begin
            u  = q_words[FLUX_VEL[i]];
            op = u[DATA_WIDTH-1] ? q_words[FLUX_DN[i]] : q_words[FLUX_UP[i]];
            prod_next[i] = PW'($signed(u)) * PW'($signed(op));
        end
    end

    always_comb
    begin
        bal_next = '0;
        for (int i = 0; i < FLUXES; i++)
        begin
            if (i % 2 == 0)
                bal_next = bal_next + BW'(b1_prod_reg[i] >>> FRAC_BITS);
            else
                bal_next = bal_next - BW'(b1_prod_reg[i] >>> FRAC_BITS);
        end
    end

    assign gain_prod = GW'(b2_bal_reg) * GW'($signed({1'b0, update_gain}));

    always_comb
    begin
        sum = RW'(b3_delta_reg) + RW'($signed(b3_c_reg));
        if ((&sum[RW-1:DATA_WIDTH-1]) || !(|sum[RW-1:DATA_WIDTH-1]))
            sat_next = sum[DATA_WIDTH-1:0];
        else if (sum[RW-1])
            sat_next = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
        else
            sat_next = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg  <= pop;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < FLUXES; i++)
                b1_prod_reg[i] <= prod_next[i];
            b1_c_reg      <= q_words[W_C];
            b1_pos_reg    <= q_pos;
            b2_bal_reg    <= bal_next;
            b2_c_reg      <= b1_c_reg;
            b2_pos_reg    <= b1_pos_reg;
            b3_delta_reg  <= gain_prod[GW-1:FRAC_BITS];
            b3_c_reg      <= b2_c_reg;
            b3_pos_reg    <= b2_pos_reg;
            new_value_reg <= sat_next;
            out_pos_reg   <= b3_pos_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_value = new_value_reg;
    assign pos_x     = out_pos_reg.pos_x;
    assign pos_y     = out_pos_reg.pos_y;
    assign pos_z     = out_pos_reg.pos_z;
    assign last_cell = out_pos_reg.last_cell;

endmodule

// File: rtl/upwind_advection_stencil_3d_unit.sv
// Top level of the 3D first-order upwind advection stencil with its register file.
//
// Cells enter on the input channel (in_valid, in_stall) one word per cell in raster
// order, x fastest, then y, then z. Each interior cell leaves on the output channel
// (out_valid, out_stall) once the cell one plane above it has arrived; boundary
// cells give no word, so results come out in raster order of interior cells.
// Throughput is one cell per clock while in_stall is low, set by the single write and
// registered read of the plane memories in the front end, which are touched once per
// accepted cell. From the triggering cell a result passes through the memory read
// registers, the queue, and the product, balance, gain and saturating output registers.
// When the receiver stalls, the output word holds, the back end freezes and the
// four-entry queue fills; in_stall rises once the queue has no slot to spare.
// Reset clears the raster counters and the pipeline and loads the default sizes and
// gain; the plane memories need no clearing and are valid after two full planes.
// Registers are written on the cfg channel (cfg_ready is always high); the user must write
// them only while the block is idle, which the block itself does not enforce.
module upwind_advection_stencil_3d_unit #(
    parameter int MAX_SIZE_X = uas3d_pkg::MAX_SIZE_X_DEF,
    parameter int MAX_SIZE_Y = uas3d_pkg::MAX_SIZE_Y_DEF,
    parameter int DATA_WIDTH = uas3d_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  uas3d_pkg::cfg_idx_t        cfg_index,
    input  logic [15:0]                cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [DATA_WIDTH-1:0]      cell_value,
    input  logic [DATA_WIDTH-1:0]      face_vel_x,
    input  logic [DATA_WIDTH-1:0]      face_vel_y,
    input  logic [DATA_WIDTH-1:0]      face_vel_z,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [DATA_WIDTH-1:0]      new_value,
    output logic [5:0]                 pos_x,
    output logic [5:0]                 pos_y,
    output logic [15:0]                pos_z,
    output logic                       last_cell
);
    import uas3d_pkg::*;

    localparam int QW = WORDS * DATA_WIDTH + $bits(pos_t);

    logic [6:0]  size_x_reg;
    logic [6:0]  size_y_reg;
    logic [15:0] size_z_reg;
    logic [15:0] gain_reg;

    logic                             push;
    logic [WORDS-1:0][DATA_WIDTH-1:0] push_words;
    pos_t                             push_pos;
    logic                             pop;
    logic                             q_empty;
    logic [QCW-1:0]                   q_count;
    logic [QW-1:0]                    q_rd_data;
    logic [WORDS-1:0][DATA_WIDTH-1:0] q_words;
    pos_t                             q_pos;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_X_RESET;
            size_y_reg <= SIZE_Y_RESET;
            size_z_reg <= SIZE_Z_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data[6:0];
                CFG_SIZE_Y: size_y_reg <= cfg_data[6:0];
                CFG_SIZE_Z: size_z_reg <= cfg_data;
                CFG_GAIN:   gain_reg   <= cfg_data;
            endcase
        end
    end

    uas3d_front #(
        .MAX_SIZE_X (MAX_SIZE_X),
        .MAX_SIZE_Y (MAX_SIZE_Y),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_value (cell_value),
        .face_vel_x (face_vel_x),
        .face_vel_y (face_vel_y),
        .face_vel_z (face_vel_z),
        .size_x     (size_x_reg),
        .size_y     (size_y_reg),
        .size_z     (size_z_reg),
        .q_count    (q_count),
        .push       (push),
        .push_words (push_words),
        .push_pos   (push_pos)
    );

    uas3d_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({push_words, push_pos}),
        .pop     (pop),
        .rd_data (q_rd_data),
        .empty   (q_empty),
        .count   (q_count)
    );

    assign q_words = q_rd_data[QW-1:$bits(pos_t)];
    assign q_pos   = q_rd_data[$bits(pos_t)-1:0];

    uas3d_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_words     (q_words),
        .q_pos       (q_pos),
        .pop         (pop),
        .update_gain (gain_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_value   (new_value),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .last_cell   (last_cell)
    );

endmodule

// File: rtl/uas3d_checker.sv
// Port-level checker for the advection stencil, bound to the top level.
module uas3d_checker #(
    parameter int DATA_WIDTH = uas3d_pkg::DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [DATA_WIDTH-1:0] new_value,
    input logic [5:0]            pos_x,
    input logic [5:0]            pos_y,
    input logic [15:0]           pos_z
);

    // No result word may be shown while reset is applied.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // A stalled result word stays offered, and its new_value and pos_z stay unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_value) && $stable(pos_z))
        else $error("stalled result word changed");

    // Only interior cells are emitted, so no coordinate is ever on the low boundary.
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pos_x != 6'd0) && (pos_y != 6'd0) && (pos_z != 16'd0))
        else $error("boundary cell emitted");

endmodule

bind upwind_advection_stencil_3d_unit uas3d_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_uas3d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_value (new_value),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z)
);
